// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, quiet while reset is asserted
`define LBC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("lbc assertion failed");

// implication into the next cycle, also checked across reset
`define LBC_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("lbc assertion failed");

`endif

// ===== src/lbc_pkg.sv =====
`default_nettype none
package lbc_pkg;

  // accumulator format is signed Q5.FRAC_BITS
  localparam int FRAC_BITS = 12;
  localparam int ACC_W     = FRAC_BITS + 6;
  localparam int Q_W       = FRAC_BITS + 1;   // normalized source value, 0..1.0
  localparam int W_W       = ACC_W + 1;       // blend weight
  localparam int SUM_W     = 2 * ACC_W + 2;
  localparam int FIX_ONE   = 1 << FRAC_BITS;
  localparam int FIX_HALF  = 1 << (FRAC_BITS - 1);

  // source normalization: q = floor((p * 2^(F+1) + 65025) / 130050)
  localparam int N_W       = FRAC_BITS + 17;
  localparam int RECIP_SH  = N_W + 18;
  localparam int M_W       = RECIP_SH - 16;
  localparam int MUL_W     = M_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int D_W       = 17;
  localparam logic [D_W-1:0] DIV_D    = D_W'(130050);
  localparam logic [N_W-1:0] DIV_BIAS = N_W'(65025);
  localparam logic [M_W-1:0] RECIP_M  = M_W'((64'd1 << RECIP_SH) / 64'd130050);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // blend factor codes, anything above the list acts as one
  localparam logic [3:0] BF_ZERO                = 4'd0;
  localparam logic [3:0] BF_ONE                 = 4'd1;
  localparam logic [3:0] BF_SRC_COLOR           = 4'd2;
  localparam logic [3:0] BF_ONE_MINUS_SRC_COLOR = 4'd3;
  localparam logic [3:0] BF_DST_COLOR           = 4'd4;
  localparam logic [3:0] BF_ONE_MINUS_DST_COLOR = 4'd5;
  localparam logic [3:0] BF_SRC_ALPHA           = 4'd6;
  localparam logic [3:0] BF_ONE_MINUS_SRC_ALPHA = 4'd7;
  localparam logic [3:0] BF_DST_ALPHA           = 4'd8;
  localparam logic [3:0] BF_ONE_MINUS_DST_ALPHA = 4'd9;

  // channel slots walked by the sequencer
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_opacity;
    logic [7:0] tint;
    logic [3:0] src_factor;
    logic [3:0] dst_factor;
    logic       base_flag;
    logic [7:0] base_coverage;
    logic       last_layer;
  } lbc_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_coverage;
  } lbc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TINT,
    ST_RECIP,
    ST_BACK,
    ST_FIX,
    ST_SRCW,
    ST_DSTW,
    ST_ACC,
    ST_EMIT
  } lbc_state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_TINT,
    MOP_RECIP,
    MOP_BACK,
    MOP_SRCW,
    MOP_DSTW
  } lbc_mop_t;

  typedef struct packed {
    logic       idle;
    logic       take;
    lbc_mop_t   mop;
    logic       ld_num;
    logic       fix;
    logic       ld_sum;
    logic       acc_wr;
    logic       emit;
    logic [1:0] chan;
  } lbc_ctl_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } lbc_sts_t;

  function automatic logic signed [W_W-1:0] blend_weight(
    input logic [3:0]              code,
    input logic [Q_W-1:0]          src_c,
    input logic [Q_W-1:0]          src_a,
    input logic signed [ACC_W-1:0] dst_c
  );
    logic signed [W_W-1:0] one_w;
    logic signed [W_W-1:0] sc;
    logic signed [W_W-1:0] sa;
    logic signed [W_W-1:0] dc;
    logic signed [W_W-1:0] w;
    one_w = W_W'(FIX_ONE);
    sc    = $signed(W_W'(src_c));
    sa    = $signed(W_W'(src_a));
    dc    = W_W'(dst_c);
    case (code)
      BF_ZERO:                w = '0;
      BF_ONE:                 w = one_w;
      BF_SRC_COLOR:           w = sc;
      BF_ONE_MINUS_SRC_COLOR: w = one_w - sc;
      BF_DST_COLOR:           w = dc;
      BF_ONE_MINUS_DST_COLOR: w = one_w - dc;
      BF_SRC_ALPHA:           w = sa;
      BF_ONE_MINUS_SRC_ALPHA: w = one_w - sa;
      BF_DST_ALPHA:           w = one_w;   // destination alpha is always one
      BF_ONE_MINUS_DST_ALPHA: w = '0;
      default:                w = one_w;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/lbc_mul.sv =====
`default_nettype none
module lbc_mul
  import lbc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  mul_a,
  input  wire logic signed [MUL_W-1:0]  mul_b,
  output logic signed      [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

// ===== src/lbc_ctrl.sv =====
`default_nettype none
module lbc_ctrl
  import lbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire lbc_sts_t sts,
  output lbc_ctl_t      ctl
);

  lbc_state_t state_r, state_nxt;
  logic [1:0] chan_r, chan_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= CH_ALPHA;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_TINT;
          chan_nxt  = CH_ALPHA;
        end
      end
      ST_TINT:  state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_BACK;
      ST_BACK:  state_nxt = ST_FIX;
      ST_FIX: begin
        // alpha is normalized first, the color channels need it as a weight
        if (chan_r == CH_ALPHA) begin
          chan_nxt  = CH_RED;
          state_nxt = ST_TINT;
        end else begin
          state_nxt = ST_SRCW;
        end
      end
      ST_SRCW: state_nxt = ST_DSTW;
      ST_DSTW: state_nxt = ST_ACC;
      ST_ACC: begin
        if (chan_r == CH_BLUE) begin
          state_nxt = sts.last ? ST_EMIT : ST_IDLE;
        end else begin
          chan_nxt  = chan_r + 2'd1;
          state_nxt = ST_TINT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.mop  = MOP_NONE;
    ctl.chan = chan_r;
    case (state_r)
      ST_IDLE: begin
        ctl.idle = 1'b1;
        ctl.take = in_valid;
      end
      ST_TINT:  ctl.mop = MOP_TINT;
      ST_RECIP: begin
        ctl.mop    = MOP_RECIP;
        ctl.ld_num = 1'b1;
      end
      ST_BACK:  ctl.mop = MOP_BACK;
      ST_FIX:   ctl.fix = 1'b1;
      ST_SRCW:  ctl.mop = MOP_SRCW;
      ST_DSTW: begin
        ctl.mop    = MOP_DSTW;
        ctl.ld_sum = 1'b1;
      end
      ST_ACC:   ctl.acc_wr = 1'b1;
      ST_EMIT:  ctl.emit = sts.out_free;
      default:  ctl.mop = MOP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/layer_blend_combiner_unit.sv =====
// one layer word is taken at a time; in_stall is high until the block is idle
// a result is registered after its last layer and held on out_valid until taken
// the pace is set by a single shared 32x32 multiplier: four steps for alpha,
// seven per color channel (tint, reciprocal, back-multiply, fix, two weights, sum)
// synchronous active-low reset clears the accumulator to zero and coverage to 255
`default_nettype none
module layer_blend_combiner_unit
  import lbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire lbc_in_t  in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output lbc_out_t      out_word
);

  lbc_ctl_t ctl;
  lbc_sts_t sts;

  lbc_in_t                    in_r;
  logic [7:0]                 cov_r;
  logic signed [ACC_W-1:0]    acc_r [3];
  logic [N_W-1:0]             num_r;
  logic [Q_W-1:0]             q_r;
  logic [Q_W-1:0]             src_a_r;
  logic [Q_W-1:0]             src_c_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       out_valid_r;
  lbc_out_t                   out_r;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod_r;

  logic [7:0]                 byte_sel;
  logic signed [ACC_W-1:0]    dst_c;
  logic signed [W_W-1:0]      sf, df;
  logic [N_W-1:0]             num_nxt;
  logic [Q_W-1:0]             q_est;
  logic [N_W:0]               rem;
  logic [Q_W-1:0]             q_fix;
  logic signed [SUM_W-1:0]    total;
  logic signed [SUM_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    acc_sat;
  logic [7:0]                 byte_out [3];

  lbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  lbc_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign sts.last     = in_r.last_layer;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign in_stall     = !ctl.idle;
  assign out_valid    = out_valid_r;
  assign out_word     = out_r;

  always_comb begin
    case (ctl.chan)
      CH_RED:   byte_sel = in_r.src_red;
      CH_GREEN: byte_sel = in_r.src_green;
      CH_BLUE:  byte_sel = in_r.src_blue;
      default:  byte_sel = in_r.src_opacity;
    endcase
    case (ctl.chan)
      CH_GREEN: dst_c = acc_r[1];
      CH_BLUE:  dst_c = acc_r[2];
      default:  dst_c = acc_r[0];
    endcase
  end

  assign sf = blend_weight(in_r.src_factor, src_c_r, src_a_r, dst_c);
  assign df = blend_weight(in_r.dst_factor, src_c_r, src_a_r, dst_c);

  // prod_r holds byte*tint (alpha uses byte*255, same divisor then applies)
  assign num_nxt = (N_W'(prod_r[15:0]) << (FRAC_BITS + 1)) + DIV_BIAS;
  // reciprocal estimate is low by at most one
  assign q_est   = prod_r[RECIP_SH +: Q_W];
  assign rem     = {1'b0, num_r} - prod_r[N_W:0];
  assign q_fix   = q_r + Q_W'(rem >= (N_W+1)'(DIV_D));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mop)
      MOP_TINT: begin
        mul_a = MUL_W'(byte_sel);
        mul_b = (ctl.chan == CH_ALPHA) ? MUL_W'(8'd255) : MUL_W'(in_r.tint);
      end
      MOP_RECIP: begin
        mul_a = MUL_W'(num_nxt);
        mul_b = MUL_W'(RECIP_M);
      end
      MOP_BACK: begin
        mul_a = MUL_W'(q_est);
        mul_b = MUL_W'(DIV_D);
      end
      MOP_SRCW: begin
        mul_a = MUL_W'(sf);
        mul_b = MUL_W'(src_c_r);
      end
      MOP_DSTW: begin
        mul_a = MUL_W'(df);
        mul_b = MUL_W'(dst_c);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up, floor shift, then saturate to the accumulator range
  assign total = sum_r + $signed(prod_r[SUM_W-1:0]);
  assign rnd   = (total + SUM_W'(FIX_HALF)) >>> FRAC_BITS;

  always_comb begin
    if (rnd > SUM_W'(ACC_MAX)) begin
      acc_sat = ACC_MAX;
    end else if (rnd < SUM_W'(ACC_MIN)) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = rnd[ACC_W-1:0];
    end
  end

  // clamp to [0,1], scale by 255, round half up
  always_comb begin
    logic [Q_W-1:0]   v;
    logic [Q_W+7:0]   scaled;
    for (int c = 0; c < 3; c++) begin
      if (acc_r[c] < 0) begin
        v = '0;
      end else if (acc_r[c] > ACC_W'(FIX_ONE)) begin
        v = Q_W'(FIX_ONE);
      end else begin
        v = acc_r[c][Q_W-1:0];
      end
      scaled      = ({v, 8'd0} - (Q_W+8)'(v)) + (Q_W+8)'(FIX_HALF);
      byte_out[c] = scaled[FRAC_BITS +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      in_r <= in_word;
    end
    if (ctl.ld_num) begin
      num_r <= num_nxt;
    end
    if (ctl.mop == MOP_BACK) begin
      q_r <= q_est;
    end
    if (ctl.fix) begin
      if (ctl.chan == CH_ALPHA) begin
        src_a_r <= q_fix;
      end else begin
        src_c_r <= q_fix;
      end
    end
    if (ctl.ld_sum) begin
      sum_r <= $signed(prod_r[SUM_W-1:0]);
    end
    if (ctl.emit) begin
      out_r.out_red      <= byte_out[0];
      out_r.out_green    <= byte_out[1];
      out_r.out_blue     <= byte_out[2];
      out_r.out_coverage <= cov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_r       <= 8'hFF;
      acc_r[0]    <= '0;
      acc_r[1]    <= '0;
      acc_r[2]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.take && in_word.base_flag) begin
        cov_r <= in_word.base_coverage;
      end else if (ctl.emit) begin
        cov_r <= 8'hFF;
      end
      if (ctl.emit) begin
        acc_r[0] <= '0;
        acc_r[1] <= '0;
        acc_r[2] <= '0;
      end else if (ctl.acc_wr) begin
        for (int c = 0; c < 3; c++) begin
          if (ctl.chan == 2'(c)) begin
            acc_r[c] <= acc_sat;
          end
        end
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/lbc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module lbc_checker
  import lbc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lbc_out_t out_word
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result word stays up and unchanged
  `LBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `LBC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_word))
  // the block is busy right after taking a layer word
  `LBC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_acc, in_stall)
  // a layer word just taken cannot produce a result on the next edge
  `LBC_ASSERT_NEXT(a_no_instant_out, clk, rst_n, in_acc, !$rose(out_valid))
  // reset leaves no result pending
  `LBC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind layer_blend_combiner_unit lbc_checker u_lbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

// ===== tb/tb_layer_blend_combiner_unit.sv =====
module tb_layer_blend_combiner_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lbc_pkg::*;

  localparam int PAUSE_MAX    = 12;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LAYER_TARGET = 1100;
  localparam longint ACC_HI   = (longint'(1) << (FRAC_BITS + 5)) - 1;
  localparam longint ACC_LO   = -(longint'(1) << (FRAC_BITS + 5));

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  lbc_in_t  in_word   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  lbc_out_t out_word;

  // predicted pixel state
  longint     blend_acc[3];
  logic [7:0] coverage_latch;

  lbc_in_t  pending_layers[$];
  lbc_out_t expected_pixels[$];

  int error_count  = 0;
  int layers_total = 0;
  int layers_sent  = 0;
  int layers_taken = 0;
  int pixels_seen  = 0;
  int in_pause     = 0;
  int out_hold     = 0;
  int quiet_cycles = 0;

  layer_blend_combiner_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint weight_of(logic [3:0] code, longint sc, longint sa, longint dc);
    case (code)
      BF_ZERO:                return 0;
      BF_SRC_COLOR:           return sc;
      BF_ONE_MINUS_SRC_COLOR: return FIX_ONE - sc;
      BF_DST_COLOR:           return dc;
      BF_ONE_MINUS_DST_COLOR: return FIX_ONE - dc;
      BF_SRC_ALPHA:           return sa;
      BF_ONE_MINUS_SRC_ALPHA: return FIX_ONE - sa;
      BF_ONE_MINUS_DST_ALPHA: return 0;
      default:                return FIX_ONE;
    endcase
  endfunction

  function automatic void clear_pixel();
    for (int c = 0; c < 3; c++) blend_acc[c] = 0;
    coverage_latch = 8'd255;
  endfunction

  // fold one layer into the pixel, queue the pixel on its last layer
  function automatic void fold_layer(lbc_in_t w);
    longint     sa;
    longint     sc;
    longint     sf;
    longint     df;
    longint     total;
    longint     v;
    logic [7:0] chan[3];
    logic [7:0] octet[3];
    chan[0] = w.src_red;
    chan[1] = w.src_green;
    chan[2] = w.src_blue;
    sa = (2 * longint'(w.src_opacity) * FIX_ONE + 255) / 510;
    for (int c = 0; c < 3; c++) begin
      sc = (2 * longint'(chan[c]) * longint'(w.tint) * FIX_ONE + 65025) / 130050;
      sf = weight_of(w.src_factor, sc, sa, blend_acc[c]);
      df = weight_of(w.dst_factor, sc, sa, blend_acc[c]);
      total = sf * sc + df * blend_acc[c];
      v = (total + FIX_ONE / 2) >>> FRAC_BITS;
      if (v > ACC_HI) v = ACC_HI;
      if (v < ACC_LO) v = ACC_LO;
      blend_acc[c] = v;
    end
    if (w.base_flag) coverage_latch = w.base_coverage;
    if (w.last_layer) begin
      for (int c = 0; c < 3; c++) begin
        v = blend_acc[c];
        if (v < 0) v = 0;
        if (v > FIX_ONE) v = FIX_ONE;
        octet[c] = 8'((v * 255 + FIX_ONE / 2) >> FRAC_BITS);
      end
      expected_pixels.push_back('{octet[0], octet[1], octet[2], coverage_latch});
      clear_pixel();
    end
  endfunction

  // every third stretch of 40 words runs without idling
  function automatic int draw_pause(int n);
    return ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, PAUSE_MAX);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic lbc_in_t random_layer();
    lbc_in_t w;
    w.src_red       = pick_byte();
    w.src_green     = pick_byte();
    w.src_blue      = pick_byte();
    w.src_opacity   = pick_byte();
    w.tint          = pick_byte();
    w.src_factor    = 4'($urandom_range(0, 15));
    w.dst_factor    = 4'($urandom_range(0, 15));
    w.base_flag     = 1'($urandom_range(0, 1));
    w.base_coverage = pick_byte();
    w.last_layer    = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_pause <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_layer(in_word);
        layers_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_pause > 0) begin
          in_valid <= 1'b0;
          in_pause <= in_pause - 1;
        end else if (pending_layers.size() > 0) begin
          in_word  <= pending_layers.pop_front();
          in_valid <= 1'b1;
          in_pause <= draw_pause(layers_sent);
          layers_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, stall is counted only while a word is waiting
  always @(posedge clk) begin : result_monitor
    lbc_out_t want;
    int       pause;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("result word with no pixel expected");
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("out_red", want.out_red, out_word.out_red);
        compare_field("out_green", want.out_green, out_word.out_green);
        compare_field("out_blue", want.out_blue, out_word.out_blue);
        compare_field("out_coverage", want.out_coverage, out_word.out_coverage);
      end
      pixels_seen++;
      pause = draw_pause(pixels_seen);
      out_hold  <= pause;
      out_stall <= (pause > 0);
    end else if (out_valid && out_stall) begin
      out_hold  <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL layer_blend_combiner_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    lbc_in_t w;
    int      depth;
    clear_pixel();

    // base and last in one word, source and tint bytes at their top
    w = '1;
    w.src_factor    = BF_ONE;
    w.dst_factor    = BF_ONE;
    w.base_coverage = 8'h5a;
    pending_layers.push_back(w);
    // no base layer, coverage stays full
    w = '0;
    w.last_layer = 1'b1;
    pending_layers.push_back(w);
    // every factor code on both sides, two base layers in one pixel
    for (int i = 0; i < 16; i++) begin
      w = random_layer();
      w.src_factor = 4'(i);
      w.dst_factor = 4'(15 - i);
      w.base_flag  = (i == 3 || i == 9);
      w.last_layer = (i == 15);
      pending_layers.push_back(w);
    end
    // build up, square into positive saturation, then swing to negative saturation
    for (int i = 0; i < 7; i++) begin
      w = '0;
      w.src_red    = 8'd255;
      w.src_green  = 8'd255;
      w.src_blue   = 8'd255;
      w.tint       = 8'd255;
      w.src_factor = (i < 3) ? BF_ONE : BF_ZERO;
      w.dst_factor = (i < 3) ? BF_ONE : (i < 5) ? BF_DST_COLOR : BF_ONE_MINUS_DST_COLOR;
      w.last_layer = (i == 6);
      pending_layers.push_back(w);
    end

    while (pending_layers.size() < LAYER_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        // long or broken runs, rarely closed
        depth = $urandom_range(1, 40);
        for (int k = 0; k < depth; k++) begin
          w = random_layer();
          w.last_layer = ($urandom_range(0, 7) == 0);
          pending_layers.push_back(w);
        end
      end else begin
        depth = $urandom_range(1, 6);
        for (int k = 0; k < depth; k++) begin
          w = random_layer();
          w.base_flag  = ($urandom_range(0, 2) == 0);
          w.last_layer = (k == depth - 1);
          pending_layers.push_back(w);
        end
      end
    end
    layers_total = pending_layers.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (layers_taken < layers_total || expected_pixels.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("PASS layer_blend_combiner_unit");
    end else begin
      $display("FAIL layer_blend_combiner_unit");
    end
    $finish;
  end

endmodule
